// ===== hdl/spq_pkg.sv =====
// Shared constants, codes and types for the sorted-list priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int PRIO_BITS  = 3;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [PRIO_BITS-1:0]         prio;
  } entry_t;

  // Operation broadcast to every cell in the chain.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t item;
  } cell_op_t;

  // Per-cell position relative to the fill count.
  typedef struct packed {
    logic occ;
    logic at_tail;
  } cell_pos_t;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, shifts right on insert ahead
// of it, takes the new entry at its insertion point, shifts left on pop.
// Depends on spq_pkg.
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_op_t  op,
  input  cell_pos_t pos,
  input  logic      left_greater,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      greater,
  output entry_t    entry
);

  logic take_new;

  // Held entry is served after the incoming one.
  assign greater  = pos.occ && (entry.prio > op.item.prio);
  assign take_new = !left_greater && (greater || pos.at_tail);

  always_ff @(posedge clk) begin
    if (op.push) begin
      if (left_greater) begin
        entry <= left_entry;
      end else if (take_new) begin
        entry <= op.item;
      end
    end else if (op.pop) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== hdl/stable_priority_queue.sv =====
// Sorted-list priority queue built as a chain of CAPACITY cells.
// The result is strobed on done in the cycle after the transfer is taken.
// Throughput: one push or pop per cycle outside reset; every cell compares and shifts at once.
// Reset: synchronous, active high; empties the queue, busy is high during reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Depends on spq_pkg and spq_cell.
module stable_priority_queue
  import spq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd,
  input  logic signed [VALUE_BITS-1:0] value_in,
  input  logic [PRIO_BITS-1:0]         priority_in,
  output logic                         done,
  output logic signed [VALUE_BITS-1:0] value_out,
  output logic [1:0]                   status,
  output logic [COUNT_BITS-1:0]        occupancy
);

  logic                  accept;
  logic                  is_full;
  logic                  is_empty;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  cell_op_t              op;
  cell_pos_t             pos     [CAPACITY];
  logic                  greater [CAPACITY];
  entry_t                entries [CAPACITY];

  // Only reset holds off a transfer; no operation keeps the queue busy.
  assign busy     = rst;
  assign accept   = start && !busy;
  assign is_full  = (count == COUNT_BITS'(CAPACITY));
  assign is_empty = (count == '0);

  // Broadcast the operation; drop a push onto a full queue, a pop on an empty one.
  assign op.push       = accept && (cmd == CMD_PUSH) && !is_full;
  assign op.pop        = accept && (cmd == CMD_POP) && !is_empty;
  assign op.item.value = value_in;
  assign op.item.prio  = priority_in;

  always_comb begin
    count_next = count;
    if (op.push) begin
      count_next = count + COUNT_BITS'(1);
    end else if (op.pop) begin
      count_next = count - COUNT_BITS'(1);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      // Slots below the fill count are occupied; the slot at the count is the tail.
      assign pos[gi].occ     = (COUNT_BITS'(gi) < count);
      assign pos[gi].at_tail = (COUNT_BITS'(gi) == count);

      if (gi == 0) begin : g_head
        spq_cell u_cell (
          .clk          (clk),
          .op           (op),
          .pos          (pos[gi]),
          .left_greater (1'b0),
          .left_entry   (op.item),
          .right_entry  ((CAPACITY > 1) ? entries[(gi + 1) % CAPACITY] : op.item),
          .greater      (greater[gi]),
          .entry        (entries[gi])
        );
      end else if (gi == CAPACITY - 1) begin : g_tail
        // Last slot: nothing to its right, a pop leaves stale data past the count.
        spq_cell u_cell (
          .clk          (clk),
          .op           (op),
          .pos          (pos[gi]),
          .left_greater (greater[gi - 1]),
          .left_entry   (entries[gi - 1]),
          .right_entry  (entries[gi]),
          .greater      (greater[gi]),
          .entry        (entries[gi])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk          (clk),
          .op           (op),
          .pos          (pos[gi]),
          .left_greater (greater[gi - 1]),
          .left_entry   (entries[gi - 1]),
          .right_entry  (entries[gi + 1]),
          .greater      (greater[gi]),
          .entry        (entries[gi])
        );
      end
    end
  endgenerate

  // Fill count and transfer strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result register: value only for a successful pop, status codes for rejects.
  always_ff @(posedge clk) begin
    if (accept) begin
      value_out <= op.pop ? entries[0].value : '0;
      occupancy <= count_next;
      if (cmd == CMD_PUSH) begin
        status <= is_full ? ST_FULL : ST_OK;
      end else begin
        status <= is_empty ? ST_EMPTY : ST_OK;
      end
    end
  end

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks for the priority queue, bound to the top level.
// Depends on spq_pkg and stable_priority_queue.
module spq_checker
  import spq_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         cmd,
  input logic signed [VALUE_BITS-1:0] value_in,
  input logic [PRIO_BITS-1:0]         priority_in,
  input logic                         done,
  input logic signed [VALUE_BITS-1:0] value_out,
  input logic [1:0]                   status,
  input logic [COUNT_BITS-1:0]        occupancy
);

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (done == $past(start && !busy)))
    else $error("done does not follow the accepted transfer");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (value_out == '0 && occupancy == '0))
    else $error("empty pop reported with data or entries");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (value_out == '0 &&
                                     occupancy == COUNT_BITS'(CAPACITY)))
    else $error("full push reported with wrong occupancy");

  a_push_status: assert property (@(posedge clk) disable iff (rst)
    (done && $past(cmd) == CMD_PUSH) |-> (status != ST_EMPTY && value_out == '0))
    else $error("push reported as pop result");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
